[rtl/core/soas_pkg.sv]
// Shared types, constants and helpers for the second-order attractor step core.
// Used by the multiply-accumulate unit and the top level; depends on nothing.

package soas_pkg;

    // Default number of joints kept in the state store.
    localparam int JOINTS_DEFAULT = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LOADED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd2;

    // Reset value of the Euler step, about 0.001 in Q0.24.
    localparam logic [23:0] STEP_SIZE_RESET = 24'd16777;

    // Shared multiplier geometry: signed A times signed 17-bit digit of B.
    localparam int MAC_A_W   = 35;
    localparam int MAC_B_W   = 17;
    localparam int MAC_P_W   = MAC_A_W + MAC_B_W;
    localparam int MAC_ACC_W = 76;

    // Saturation limits on a 52-bit signed intermediate.
    localparam logic signed [51:0] SAT_HI = 52'sh0_0000_7FFF_FFFF;
    localparam logic signed [51:0] SAT_LO = -52'sh0_0000_8000_0000;

    // One command to the multiply-accumulate unit.
    typedef struct packed {
        logic       issue;  // a product is started this cycle
        logic       clear;  // the accumulator restarts from this product
        logic [1:0] digit;  // product weight: 16 bits per step
    } mac_op_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DONE
    } state_t;

    // Clamp a signed value to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
        logic signed [31:0] r;
        if (x > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/soas_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.

module soas_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/soas_mac.sv]
// Shared multiply-accumulate unit: one 35 x 17 signed product per cycle,
// registered, then added into a wide accumulator at a weight of 16 bits per digit.
// Depends on soas_pkg.

module soas_mac
    import soas_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mac_op_t                     op,
    input  logic signed [MAC_A_W-1:0]   a,
    input  logic signed [MAC_B_W-1:0]   b,
    output logic signed [MAC_ACC_W-1:0] acc
);

    logic signed [MAC_P_W-1:0]   prod_reg;
    logic signed [MAC_P_W-1:0]   prod_next;
    mac_op_t                     op_reg;
    logic signed [MAC_ACC_W-1:0] acc_reg;
    logic signed [MAC_ACC_W-1:0] acc_next;
    logic signed [MAC_ACC_W-1:0] prod_ext;
    logic [5:0]                  shamt;

    // First stage: the product alone, both factors sign-extended to the product width.
    assign prod_next = MAC_P_W'(a) * MAC_P_W'(b);

    always_ff @(posedge aclk) begin
        if (op.issue) begin
            prod_reg <= prod_next;
        end
    end

    // The command is registered alongside its product, so both reach the second stage together.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= '0;
        end else begin
            op_reg <= op;
        end
    end

    // Second stage: weight the product and add it in.
    assign prod_ext = {{(MAC_ACC_W - MAC_P_W){prod_reg[MAC_P_W-1]}}, prod_reg};
    assign shamt    = {op_reg.digit, 4'b0000};
    assign acc_next = (op_reg.clear ? '0 : acc_reg) + (prod_ext << shamt);

    always_ff @(posedge aclk) begin
        if (op_reg.issue) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

[rtl/core/second_order_attractor_step_core.sv]
// One forward-Euler step of a critically damped attractor per joint, Q16.16.
// Accepts one input beat, then stays busy through the load, run and done states
// before the next beat can be taken: all products go through one shared 35 x 17
// multiplier, ten passes per item, under a fixed step sequence. A beat for an
// out-of-range joint, or for a joint not yet captured that carries no measurement,
// is taken without leaving idle and gives no result. The result stays in an output
// register, so the next beat is taken while a result waits. No clearing pass is
// needed after reset. Depends on soas_pkg, soas_mac and soas_ram.

module second_order_attractor_step_core
    import soas_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata from bit 0: joint[5:0], measured_angle[37:6], measured_velocity[69:38],
    // desired_angle[101:70], desired_velocity[133:102], zero fill[135:134]
    input  logic [135:0]         s_tdata,
    // tuser: measured_valid
    input  logic                 s_tuser,
    // Result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata from bit 0: out_joint[5:0], new_angle[37:6], new_velocity[69:38],
    // zero fill[71:70]
    output logic [71:0]          m_tdata,
    // Configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]          cfg_wr_data
);

    localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    // Step sequence while running.
    localparam logic [3:0] STEP_KK     = 4'd0;
    localparam logic [3:0] STEP_P1_LO  = 4'd1;
    localparam logic [3:0] STEP_P1_HI  = 4'd2;
    localparam logic [3:0] STEP_T1_LO  = 4'd3;
    localparam logic [3:0] STEP_T1_HI  = 4'd4;
    localparam logic [3:0] STEP_T2     = 4'd5;
    localparam logic [3:0] STEP_T1_CAP = 4'd6;
    localparam logic [3:0] STEP_ACCEL  = 4'd7;
    localparam logic [3:0] STEP_P2_0   = 4'd8;
    localparam logic [3:0] STEP_P2_1   = 4'd9;
    localparam logic [3:0] STEP_P2_2   = 4'd10;
    localparam logic [3:0] STEP_P2_3   = 4'd11;
    localparam logic [3:0] STEP_DRAIN  = 4'd12;
    localparam logic [3:0] STEP_FIN    = 4'd13;

    // Input beat fields.
    logic [5:0]         s_joint;
    logic signed [31:0] s_meas_angle;
    logic signed [31:0] s_meas_vel;
    logic signed [31:0] s_des_angle;
    logic signed [31:0] s_des_vel;

    assign s_joint      = s_tdata[5:0];
    assign s_meas_angle = s_tdata[37:6];
    assign s_meas_vel   = s_tdata[69:38];
    assign s_des_angle  = s_tdata[101:70];
    assign s_des_vel    = s_tdata[133:102];

    // Control state.
    state_t              state_reg, state_next;
    logic [3:0]          step_reg;
    logic [JOINTS-1:0]   captured_reg;
    logic                m_tvalid_reg;
    logic [15:0]         gain_reg;
    logic                gain_loaded_reg;
    logic [23:0]         step_size_reg;

    // Payload state.
    logic [5:0]          joint_reg;
    logic                fresh_reg;
    logic signed [31:0]  meas_angle_reg, meas_vel_reg;
    logic signed [31:0]  des_angle_reg, des_vel_reg;
    logic signed [31:0]  pos_reg, vel_reg;
    logic signed [32:0]  npos_reg, nvel_reg;
    logic [31:0]         kk_reg;
    logic signed [34:0]  dpos_reg;
    logic signed [49:0]  t1_reg;
    logic signed [49:0]  accel_reg;
    logic signed [31:0]  res_pos_reg, res_vel_reg;
    logic [71:0]         m_tdata_reg;

    // Handshake and sequencing signals.
    logic                in_beat;
    logic                in_range;
    logic                joint_captured;
    logic                go;
    logic                out_free;
    logic                finish;

    // Shared unit interface.
    mac_op_t                     mac_op;
    logic signed [MAC_A_W-1:0]   mac_a;
    logic signed [MAC_B_W-1:0]   mac_b;
    logic signed [MAC_ACC_W-1:0] mac_acc;
    logic signed [MAC_ACC_W-1:0] neg_acc;

    // State store port.
    logic                ram_rd_en;
    logic [63:0]         ram_rd_data;
    logic [63:0]         ram_wr_data;

    // Final sums.
    logic signed [34:0]  dpos_eff;
    logic signed [49:0]  dvel_eff;
    logic signed [51:0]  pos_sum, vel_sum;

    // Beat acceptance and the decision whether it starts a step.
    assign in_beat        = s_tvalid && s_tready;
    assign in_range       = ({1'b0, s_joint} < 7'(JOINTS));
    assign joint_captured = captured_reg[s_joint[AW-1:0]];
    assign go             = in_beat && in_range && (joint_captured || s_tuser);
    assign out_free       = !m_tvalid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (go) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (step_reg == STEP_FIN) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: handshake, store port and shared unit commands.
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        ram_rd_en = go;
        finish    = (state_reg == ST_DONE) && out_free;
        mac_op    = '0;
        mac_a     = '0;
        mac_b     = '0;
        if (state_reg == ST_RUN) begin
            case (step_reg)
                STEP_KK: begin
                    mac_op = '{issue: 1'b1, clear: 1'b1, digit: 2'd0};
                    mac_a  = {19'b0, gain_reg};
                    mac_b  = {1'b0, gain_reg};
                end
                STEP_P1_LO: begin
                    mac_op = '{issue: 1'b1, clear: 1'b1, digit: 2'd0};
                    mac_a  = {{2{nvel_reg[32]}}, nvel_reg};
                    mac_b  = {1'b0, step_size_reg[15:0]};
                end
                STEP_P1_HI: begin
                    mac_op = '{issue: 1'b1, clear: 1'b0, digit: 2'd1};
                    mac_a  = {{2{nvel_reg[32]}}, nvel_reg};
                    mac_b  = {9'b0, step_size_reg[23:16]};
                end
                STEP_T1_LO: begin
                    mac_op = '{issue: 1'b1, clear: 1'b1, digit: 2'd0};
                    mac_a  = {{2{npos_reg[32]}}, npos_reg};
                    mac_b  = {1'b0, kk_reg[15:0]};
                end
                STEP_T1_HI: begin
                    mac_op = '{issue: 1'b1, clear: 1'b0, digit: 2'd1};
                    mac_a  = {{2{npos_reg[32]}}, npos_reg};
                    mac_b  = {1'b0, kk_reg[31:16]};
                end
                STEP_T2: begin
                    mac_op = '{issue: 1'b1, clear: 1'b1, digit: 2'd0};
                    mac_a  = {{2{nvel_reg[32]}}, nvel_reg};
                    mac_b  = {1'b0, gain_reg};
                end
                STEP_P2_0: begin
                    mac_op = '{issue: 1'b1, clear: 1'b1, digit: 2'd0};
                    mac_a  = {11'b0, step_size_reg};
                    mac_b  = {1'b0, accel_reg[15:0]};
                end
                STEP_P2_1: begin
                    mac_op = '{issue: 1'b1, clear: 1'b0, digit: 2'd1};
                    mac_a  = {11'b0, step_size_reg};
                    mac_b  = {1'b0, accel_reg[31:16]};
                end
                STEP_P2_2: begin
                    mac_op = '{issue: 1'b1, clear: 1'b0, digit: 2'd2};
                    mac_a  = {11'b0, step_size_reg};
                    mac_b  = {1'b0, accel_reg[47:32]};
                end
                STEP_P2_3: begin
                    mac_op = '{issue: 1'b1, clear: 1'b0, digit: 2'd3};
                    mac_a  = {11'b0, step_size_reg};
                    mac_b  = {{15{accel_reg[49]}}, accel_reg[49:48]};
                end
                default: begin
                    mac_op = '0;
                end
            endcase
        end
    end

    // Control registers, configuration and capture flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            captured_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
            gain_reg        <= '0;
            gain_loaded_reg <= 1'b0;
            step_size_reg   <= STEP_SIZE_RESET;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_RUN) begin
                step_reg <= step_reg + 4'd1;
            end else begin
                step_reg <= '0;
            end
            if (go) begin
                captured_reg[s_joint[AW-1:0]] <= 1'b1;
            end
            if (finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_GAIN:        gain_reg        <= cfg_wr_data[15:0];
                    CFG_GAIN_LOADED: gain_loaded_reg <= cfg_wr_data[0];
                    CFG_STEP_SIZE:   step_size_reg   <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Combinational helpers for the final sums.
    assign neg_acc  = -mac_acc;
    assign dpos_eff = gain_loaded_reg ? dpos_reg : '0;
    assign dvel_eff = gain_loaded_reg ? mac_acc[73:24] : '0;
    assign pos_sum  = {{20{pos_reg[31]}}, pos_reg} + {{17{dpos_eff[34]}}, dpos_eff};
    assign vel_sum  = {{20{vel_reg[31]}}, vel_reg} + {{2{dvel_eff[49]}}, dvel_eff};

    // Datapath registers, loaded step by step.
    always_ff @(posedge aclk) begin
        if (go) begin
            joint_reg      <= s_joint;
            fresh_reg      <= !joint_captured;
            meas_angle_reg <= s_meas_angle;
            meas_vel_reg   <= s_meas_vel;
            des_angle_reg  <= s_des_angle;
            des_vel_reg    <= s_des_vel;
        end
        if (state_reg == ST_LOAD) begin
            pos_reg <= fresh_reg ? meas_angle_reg : ram_rd_data[31:0];
            vel_reg <= fresh_reg ? meas_vel_reg : ram_rd_data[63:32];
        end
        if (state_reg == ST_RUN) begin
            case (step_reg)
                STEP_KK: begin
                    npos_reg <= {des_angle_reg[31], des_angle_reg} - {pos_reg[31], pos_reg};
                    nvel_reg <= {des_vel_reg[31], des_vel_reg} - {vel_reg[31], vel_reg};
                end
                STEP_P1_HI: begin
                    // The accumulator holds gain squared.
                    kk_reg <= mac_acc[31:0];
                end
                STEP_T1_HI: begin
                    // Position change: floor of -dt * n_vel over 2^24.
                    dpos_reg <= neg_acc[58:24];
                end
                STEP_T1_CAP: begin
                    // Floor of kk * n_pos over 2^16.
                    t1_reg <= mac_acc[65:16];
                end
                STEP_ACCEL: begin
                    // Add the floor of gain * n_vel over 2^7.
                    accel_reg <= t1_reg + mac_acc[56:7];
                end
                STEP_FIN: begin
                    res_pos_reg <= sat32(pos_sum);
                    res_vel_reg <= sat32(vel_sum);
                end
                default: begin
                end
            endcase
        end
        if (finish) begin
            m_tdata_reg <= {2'b00, res_vel_reg, res_pos_reg, joint_reg};
        end
    end

    assign ram_wr_data = {res_vel_reg, res_pos_reg};

    // Shared multiply-accumulate unit.
    soas_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (mac_op),
        .a       (mac_a),
        .b       (mac_b),
        .acc     (mac_acc)
    );

    // Per-joint position and velocity store.
    soas_ram #(
        .WIDTH (64),
        .DEPTH (JOINTS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (finish),
        .wr_addr (joint_reg[AW-1:0]),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (s_joint[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // A result beat is only raised by the closing step of the sequence.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside the closing step");

    // Every result names a joint that exists.
    a_result_joint_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[5:0]} < 7'(JOINTS)))
        else $error("result beat for a joint out of range");

    // The shared unit is never started while the block waits for a beat.
    a_mac_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mac_op.issue)
        else $error("multiplier started while idle");

    // A store write ends the item and frees the input side.
    a_write_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (state_reg == ST_IDLE))
        else $error("store written without returning to idle");
`endif

endmodule

[sim/second_order_attractor_step_core_test.sv]
// Self-checking testbench for the second-order attractor step core.
// Holds its own per-joint attractor predictor and stream driver and monitor.
// Depends on soas_pkg and second_order_attractor_step_core.
`timescale 1ns / 1ps

module second_order_attractor_step_core_test;
    import soas_pkg::*;

    localparam int JOINTS = JOINTS_DEFAULT;
    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 7;
    // Lets the core finish anything still in flight before the next register write.
    localparam int SETTLE_CYCLES = 40;
    // Longest quiet spell of a correct run: the receiver hold-off plus the tails of the
    // 85 % idle patterns and the core's own step, taken with margin.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BEATS_PER_PHASE = 65;
    // Register index with no register behind it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One input beat, and the new state of one joint.
    typedef struct packed {
        logic [5:0]         joint;
        logic               meas_valid;
        logic signed [31:0] meas_angle;
        logic signed [31:0] meas_vel;
        logic signed [31:0] des_angle;
        logic signed [31:0] des_vel;
    } joint_beat_t;

    typedef struct packed {
        logic [5:0]         joint;
        logic signed [31:0] angle;
        logic signed [31:0] velocity;
    } joint_state_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // tdata from bit 0: joint, measured_angle, measured_velocity, desired_angle,
    // desired_velocity, zero fill
    logic [135:0]         s_tdata = '0;
    // tuser: measured_valid
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // tdata from bit 0: out_joint, new_angle, new_velocity, zero fill
    logic [71:0]          m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [23:0]          cfg_wr_data = '0;

    // Predictor state: register copies and per-joint store.
    logic [15:0]        gain_m = '0;
    logic               loaded_m = 1'b0;
    logic [23:0]        step_m = STEP_SIZE_RESET;
    logic signed [31:0] pos_mem [JOINTS];
    logic signed [31:0] vel_mem [JOINTS];
    bit                 captured [JOINTS];

    joint_beat_t  pending_beats [$];
    joint_state_t expected_states [$];
    joint_beat_t  cur_beat;

    int  send_pct = 0;
    int  recv_pct = 0;
    bit  send_hold = 1'b0;
    int  hold_len = 0;
    int  hold_seq = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  errors = 0;
    int  beats_taken = 0;
    int  silent_beats = 0;
    int  results_seen = 0;
    int  settings_used = 0;
    int  quiet_cycles = 0;

    second_order_attractor_step_core #(
        .JOINTS(JOINTS)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] clamp_q16(input longint x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (x < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // One Euler step of the attractor for the beat's joint. Returns 0 where the
    // beat gives no result. Arithmetic shifts on longint are floor divisions.
    function automatic bit attractor_step(input joint_beat_t b, output joint_state_t r);
        longint pos, vel, n_pos, n_vel, kk, kh, kl, dh, dl, accel, dpos, dvel;
        int     j;
        j = b.joint;
        dpos = 0;
        dvel = 0;
        if (j >= JOINTS) begin
            return 1'b0;
        end
        // A joint not yet captured takes its state from the first measurement.
        if (!captured[j]) begin
            if (!b.meas_valid) begin
                return 1'b0;
            end
            pos_mem[j] = b.meas_angle;
            vel_mem[j] = b.meas_vel;
            captured[j] = 1'b1;
        end
        pos = longint'($signed(pos_mem[j]));
        vel = longint'($signed(vel_mem[j]));
        if (loaded_m) begin
            kk = longint'(gain_m) * longint'(gain_m);
            kh = kk >>> 16;
            kl = kk & 64'hFFFF;
            n_pos = longint'($signed(b.des_angle)) - pos;
            n_vel = longint'($signed(b.des_vel)) - vel;
            accel = kh * n_pos + ((kl * n_pos) >>> 16)
                  + ((longint'(gain_m) * n_vel) >>> 7);
            dpos = (longint'(step_m) * (-n_vel)) >>> 24;
            dh = longint'(step_m >> 12);
            dl = longint'(step_m & 24'hFFF);
            dvel = (accel * dh + ((accel * dl) >>> 12)) >>> 12;
        end
        pos_mem[j] = clamp_q16(pos + dpos);
        vel_mem[j] = clamp_q16(vel + dvel);
        r.joint = b.joint;
        r.angle = pos_mem[j];
        r.velocity = vel_mem[j];
        return 1'b1;
    endfunction

    function automatic joint_beat_t make_beat(input int j, input bit v,
                                              input logic [31:0] ma, input logic [31:0] mv,
                                              input logic [31:0] da, input logic [31:0] dv);
        joint_beat_t b;
        b.joint = 6'(j);
        b.meas_valid = v;
        b.meas_angle = ma;
        b.meas_vel = mv;
        b.des_angle = da;
        b.des_vel = dv;
        return b;
    endfunction

    // Extremes, full-range words and small values around zero.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        case ($urandom_range(0, 7))
            0: w = 32'h7FFF_FFFF;
            1: w = 32'h8000_0000;
            2, 3, 4: w = $urandom();
            default: w = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
        endcase
        return w;
    endfunction

    // Mostly joints in range; one beat in ten addresses a joint that does not exist.
    function automatic joint_beat_t random_beat();
        int j;
        if ($urandom_range(0, 9) == 0) begin
            j = $urandom_range(JOINTS, 63);
        end else begin
            j = $urandom_range(0, JOINTS - 1);
        end
        return make_beat(j, 1'($urandom_range(0, 1)), random_word(), random_word(),
                         random_word(), random_word());
    endfunction

    // Register copies follow the write port on the same edge as the core.
    always @(posedge aclk) begin
        if (aresetn && cfg_wr_en) begin
            case (cfg_index)
                CFG_GAIN: gain_m <= cfg_wr_data[15:0];
                CFG_GAIN_LOADED: loaded_m <= cfg_wr_data[0];
                CFG_STEP_SIZE: step_m <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Input driver: predicts each accepted beat, then offers the next one.
    always @(posedge aclk) begin : input_driver
        joint_state_t res;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                beats_taken++;
                if (attractor_step(cur_beat, res)) begin
                    expected_states.push_back(res);
                end else begin
                    silent_beats++;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (pending_beats.size() != 0 && !send_hold
                        && $urandom_range(1, 100) > send_pct) begin
                    cur_beat = pending_beats.pop_front();
                    s_tdata <= {2'b00, cur_beat.des_vel, cur_beat.des_angle,
                                cur_beat.meas_vel, cur_beat.meas_angle, cur_beat.joint};
                    s_tuser <= cur_beat.meas_valid;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each beat against the oldest expectation and
    // drives the ready side, including long hold-offs on request.
    always @(posedge aclk) begin : result_monitor
        joint_state_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_states.size() == 0) begin
                    $error("result beat for joint %0d with no result expected", m_tdata[5:0]);
                    errors++;
                end else begin
                    want = expected_states.pop_front();
                    results_seen++;
                    if (m_tdata[5:0] !== want.joint) begin
                        $error("out_joint mismatch: expected %0d, got %0d",
                               want.joint, m_tdata[5:0]);
                        errors++;
                    end
                    if (m_tdata[37:6] !== want.angle) begin
                        $error("new_angle mismatch on joint %0d: expected %0d, got %0d",
                               want.joint, want.angle, $signed(m_tdata[37:6]));
                        errors++;
                    end
                    if (m_tdata[69:38] !== want.velocity) begin
                        $error("new_velocity mismatch on joint %0d: expected %0d, got %0d",
                               want.joint, want.velocity, $signed(m_tdata[69:38]));
                        errors++;
                    end
                end
            end
            if (hold_seq != hold_seen) begin
                hold_seen <= hold_seq;
                hold_left <= hold_len;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(1, 100) > recv_pct);
            end
        end
    end

    // Watchdog: counts cycles in which work is pending but no beat moves.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (pending_beats.size() == 0 && !s_tvalid && expected_states.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_states.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_setting(input logic [15:0] g, input logic loaded,
                                 input logic [23:0] dt);
        write_reg(CFG_GAIN, {8'd0, g});
        write_reg(CFG_GAIN_LOADED, {23'd0, loaded});
        write_reg(CFG_STEP_SIZE, dt);
        settings_used++;
    endtask

    // Waits until every beat is taken and every result has come, then lets
    // the core settle so that register writes find it idle.
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (pending_beats.size() != 0 || s_tvalid || expected_states.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic queue_random(input int n, input int sp, input int rp);
        @(negedge aclk);
        send_pct = sp;
        recv_pct = rp;
        repeat (n) pending_beats.push_back(random_beat());
    endtask

    initial begin
        int sp, rp, mark;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: the gain was never loaded, so captured joints hold.
        pending_beats.push_back(make_beat(3, 1'b0, 32'd1, 32'd2, 32'd3, 32'd4));
        pending_beats.push_back(make_beat(3, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
        pending_beats.push_back(make_beat(3, 1'b1, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(8, 1'b1, 32'd5, 32'd6, 32'd7, 32'd8));
        pending_beats.push_back(make_beat(63, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_beats.push_back(make_beat(0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 32'h8000_0000));
        pending_beats.push_back(make_beat(7, 1'b1, 0, 0, 0, 0));
        wait_idle();

        // A write to the unused index must change nothing.
        write_reg(CFG_UNUSED, 24'hFF_FFFF);
        @(negedge aclk);
        pending_beats.push_back(make_beat(0, 1'b0, 0, 0, 32'h0001_0000, 32'h0001_0000));
        wait_idle();

        // Largest gain and step: drives both outputs into saturation.
        apply_setting(16'hFFFF, 1'b1, 24'hFF_FFFF);
        @(negedge aclk);
        pending_beats.push_back(make_beat(3, 1'b0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
        pending_beats.push_back(make_beat(0, 1'b0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_beats.push_back(make_beat(3, 1'b0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
        pending_beats.push_back(make_beat(7, 1'b0, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(0, 1'b1, 0, 0, 32'hFFFF_0000, 32'h0000_8000));
        wait_idle();

        // Unit gain with half a second of step.
        apply_setting(16'd256, 1'b1, 24'h80_0000);
        @(negedge aclk);
        pending_beats.push_back(make_beat(7, 1'b0, 0, 0, 32'h0001_0000, 32'hFFFF_0000));
        pending_beats.push_back(make_beat(7, 1'b0, 0, 0, 32'h0001_0000, 32'hFFFF_0000));
        pending_beats.push_back(make_beat(7, 1'b0, 0, 0, 32'h0001_0000, 32'hFFFF_0000));
        pending_beats.push_back(make_beat(0, 1'b0, 0, 0, 0, 0));
        wait_idle();

        // Zero step: every state holds.
        apply_setting(16'hFFFF, 1'b1, 24'd0);
        @(negedge aclk);
        pending_beats.push_back(make_beat(3, 1'b0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_beats.push_back(make_beat(0, 1'b1, 0, 0, 32'h8000_0000, 32'h8000_0000));
        wait_idle();

        // Random phases: each register setting under each idle pattern.
        for (int s = 0; s < 6; s++) begin
            for (int m = 0; m < 4; m++) begin
                case (m)
                    0: begin sp = 0;  rp = 0;  end
                    1: begin sp = 85; rp = 0;  end
                    2: begin sp = 0;  rp = 85; end
                    default: begin sp = 35; rp = 35; end
                endcase
                case (s)
                    0: apply_setting(16'd2560, 1'b1, STEP_SIZE_RESET);
                    1: apply_setting(16'hFFFF, 1'b1, 24'hFF_FFFF);
                    2: apply_setting(16'($urandom_range(0, 65535)), 1'b1,
                                     24'($urandom_range(0, 24'hFF_FFFF)));
                    3: apply_setting(16'($urandom_range(0, 65535)), 1'b0,
                                     24'($urandom_range(0, 24'hFF_FFFF)));
                    4: apply_setting(16'd0, 1'b1, 24'($urandom_range(0, 24'hFF_FFFF)));
                    default: apply_setting(16'd1, 1'b1, 24'd1);
                endcase
                mark = beats_taken + 20;
                queue_random(RANDOM_BEATS_PER_PHASE, sp, rp);
                // Receiver holds off while the sender keeps offering beats.
                if (s == 0 && m == 0) begin
                    hold_len = 400;
                    hold_seq++;
                end
                // Sender stops until the core has returned every result.
                if (s == 2 && m == 0) begin
                    do begin
                        @(negedge aclk);
                    end while (beats_taken < mark);
                    send_hold = 1'b1;
                    do begin
                        @(negedge aclk);
                    end while (s_tvalid || expected_states.size() != 0);
                    send_hold = 1'b0;
                end
                wait_idle();
            end
        end

        if (expected_states.size() != 0) begin
            $error("%0d expected results never arrived", expected_states.size());
            errors++;
        end
        $display("Covered %0d input beats (%0d without result) and %0d checked results",
                 beats_taken, silent_beats, results_seen);
        $display("over %0d register settings, four idle patterns, a hold-off and a pause.",
                 settings_used);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
